// ----- rtl/mu8_pkg.sv -----
// shared constants and types for the modified utf-8 string decoder
package mu8_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CountW = 64;
  localparam int unsigned AddrW  = 2;
  localparam int unsigned DataW  = 32;

  typedef logic [KindW-1:0] kind_t;

  // result kinds
  localparam kind_t KIND_CHAR  = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  // register map (byte addresses)
  localparam logic [AddrW-1:0] ADDR_LONG_FORM = 2'd0;

  // length prefix sizes in bytes
  localparam logic [3:0] PREFIX_SHORT = 4'd2;
  localparam logic [3:0] PREFIX_LONG  = 4'd8;

endpackage

// ----- rtl/modified_utf8_string_decoder.sv -----
// modified utf-8 string decoder: length prefix parse and body decode, one byte per cycle unless stalled
// path: each byte is held in the input register, and its result is then written to the result register
// throughput: one byte per cycle unless stalled; the state update is a single 64-bit decrement and compare
// the input stage stalls only while a result-producing byte waits on a stalled result register
// reset: asynchronous active-low rst_ni clears the decode state, both valid flags and the
// long form register, so the block starts by reading a 2-byte length prefix
module modified_utf8_string_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mu8_pkg::ByteW-1:0]   in_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mu8_pkg::UnitW-1:0]   code_unit_o,
  output logic [mu8_pkg::KindW-1:0]   kind_o,
  output logic                        last_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mu8_pkg::AddrW-1:0]   paddr,
  input  logic [mu8_pkg::DataW-1:0]   pwdata,
  output logic [mu8_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  // decoder phases
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  // configuration register
  logic long_q;

  // input register
  logic                      in_vld_q;
  logic [mu8_pkg::ByteW-1:0] byte_q;

  // decode state
  logic [1:0]                 phase_q, phase_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic [mu8_pkg::CountW-1:0] left_q, left_d;
  logic [mu8_pkg::UnitW-1:0]  part_q, part_d;
  logic [1:0]                 due_q, due_d;

  // result register
  logic                      out_vld_q;
  logic [mu8_pkg::UnitW-1:0] unit_q;
  mu8_pkg::kind_t            kind_q;
  logic                      last_q;

  // combinational result of the byte held in the input register
  logic                       res_vld;
  logic [mu8_pkg::UnitW-1:0]  res_unit;
  mu8_pkg::kind_t             res_kind;
  logic                       res_last;

  logic [mu8_pkg::CountW-1:0] left_dec;
  logic [mu8_pkg::CountW-1:0] acc;
  logic [mu8_pkg::CountW-1:0] count_val;
  logic [3:0]                 cnt_inc;
  logic [3:0]                 need;
  logic                       one_left;
  logic [mu8_pkg::UnitW-1:0]  cont_char;

  logic advance;
  logic in_take;
  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // configuration port: single register, zero wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == mu8_pkg::ADDR_LONG_FORM);
  assign prdata = (paddr == mu8_pkg::ADDR_LONG_FORM) ?
                  {{(mu8_pkg::DataW-1){1'b0}}, long_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= 1'b0;
    end else if (cfg_wr) begin
      long_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the held byte moves on unless it yields a result that cannot
  // be parked because the result register is full and stalled
  // ---------------------------------------------------------------------------
  assign advance    = in_vld_q && (!res_vld || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= in_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // decode of one byte
  // ---------------------------------------------------------------------------
  assign left_dec  = left_q - {{(mu8_pkg::CountW-1){1'b0}}, 1'b1};
  assign one_left  = (left_q[mu8_pkg::CountW-1:1] == '0);
  assign cnt_inc   = {1'b0, cnt_q} + 4'd1;
  assign need      = long_q ? mu8_pkg::PREFIX_LONG : mu8_pkg::PREFIX_SHORT;
  // count accumulates big-endian; the first prefix byte starts from zero
  assign acc       = {((cnt_q == 3'd0) ? {mu8_pkg::ByteW{1'b0}} :
                       left_q[mu8_pkg::CountW-mu8_pkg::ByteW-1 -: mu8_pkg::ByteW]),
                      left_q[mu8_pkg::CountW-mu8_pkg::ByteW-1-mu8_pkg::ByteW:0] &
                      {(mu8_pkg::CountW-2*mu8_pkg::ByteW){cnt_q != 3'd0}},
                      byte_q};
  // a negative long count reads as an empty string
  assign count_val = (long_q && acc[mu8_pkg::CountW-1]) ? '0 : acc;
  assign cont_char = {part_q[mu8_pkg::UnitW-7:0], byte_q[5:0]};

  always_comb begin
    res_vld  = 1'b0;
    res_unit = '0;
    res_kind = mu8_pkg::KIND_CHAR;
    res_last = 1'b0;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    part_d   = part_q;
    due_d    = due_q;

    case (phase_q)
      PH_SKIP: begin
        // drop the rest of a bad string silently
        if (left_q != '0) begin
          left_d = left_dec;
        end
        if (one_left) begin
          phase_d = PH_PREFIX;
        end
      end

      PH_BODY: begin
        left_d = left_dec;
        if (due_q != 2'd0) begin
          if (byte_q[7:6] != 2'b10) begin
            res_vld = 1'b1;
          end else if (due_q == 2'd1) begin
            due_d    = 2'd0;
            part_d   = '0;
            res_vld  = 1'b1;
            res_unit = cont_char;
            res_last = one_left;
            if (one_left) begin
              phase_d = PH_PREFIX;
            end
          end else begin
            due_d  = due_q - 2'd1;
            part_d = cont_char;
          end
        end else if (!byte_q[7]) begin
          part_d   = '0;
          res_vld  = 1'b1;
          res_unit = {{(mu8_pkg::UnitW-mu8_pkg::ByteW){1'b0}}, byte_q};
          res_last = one_left;
          if (one_left) begin
            phase_d = PH_PREFIX;
          end
        end else if (byte_q[7:5] == 3'b110) begin
          if (one_left) begin
            res_vld = 1'b1;
          end else begin
            part_d = {{(mu8_pkg::UnitW-5){1'b0}}, byte_q[4:0]};
            due_d  = 2'd1;
          end
        end else if (byte_q[7:4] == 4'b1110) begin
          if (left_q < 64'd3) begin
            res_vld = 1'b1;
          end else begin
            part_d = {{(mu8_pkg::UnitW-4){1'b0}}, byte_q[3:0]};
            due_d  = 2'd2;
          end
        end else begin
          res_vld = 1'b1;
        end

        // a result that is not a character here is a format error
        if (res_vld && (res_unit == '0) && !res_last && (due_d == due_q || due_q != 2'd0)
            && !(due_q == 2'd1 && byte_q[7:6] == 2'b10)
            && !(due_q == 2'd0 && !byte_q[7])) begin
          res_kind = mu8_pkg::KIND_ERROR;
          res_last = 1'b1;
          part_d   = '0;
          due_d    = 2'd0;
          phase_d  = one_left ? PH_PREFIX : PH_SKIP;
        end
      end

      default: begin
        // length prefix, also taken for the unused phase code
        left_d = acc;
        cnt_d  = cnt_inc[2:0];
        if (cnt_inc >= need) begin
          cnt_d  = 3'd0;
          part_d = '0;
          due_d  = 2'd0;
          left_d = count_val;
          if (count_val == '0) begin
            phase_d  = PH_PREFIX;
            res_vld  = 1'b1;
            res_kind = mu8_pkg::KIND_EMPTY;
            res_last = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      cnt_q   <= 3'd0;
      left_q  <= '0;
      part_q  <= '0;
      due_q   <= 2'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      part_q  <= part_d;
      due_q   <= due_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      unit_q <= res_unit;
      kind_q <= res_kind;
      last_q <= res_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign code_unit_o = unit_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  // errors and empty ends always close the string and carry no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (kind_q != mu8_pkg::KIND_CHAR) |-> last_q && (unit_q == '0))
    else $error("non-character result without last or with a code unit");

  // inside a body there is always at least one byte still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (left_q != '0))
    else $error("body phase with zero bytes left");

  // continuation bytes are only pending inside a body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q != 2'd0) |-> (phase_q == PH_BODY))
    else $error("continuations pending outside a body");

  // the input side stalls only behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked result");
`endif

endmodule
